/* sv/vag_pkg.sv */
package vag_pkg;

    localparam int LINE_BYTES   = 16;
    localparam int FILTER_SHIFT = 6;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [3:0] POS_SHIFT = 4'd0;
    localparam logic [3:0] POS_FLAGS = 4'd1;
    localparam logic [3:0] POS_FIRST = 4'd2;
    localparam logic [3:0] POS_LAST  = 4'(LINE_BYTES - 1);

    localparam int FLAG_END  = 0;
    localparam int FLAG_LOOP = 2;

    localparam logic [1:0] LCNT_MAX  = 2'd3;
    localparam logic [1:0] LCNT_LOOP = 2'd2;

    localparam logic signed [7:0] F0_P1 = 8'sd60;
    localparam logic signed [7:0] F0_P2 = 8'sd115;
    localparam logic signed [7:0] F0_P3 = 8'sd98;
    localparam logic signed [7:0] F0_P4 = 8'sd122;
    localparam logic signed [7:0] F1_P2 = -8'sd52;
    localparam logic signed [7:0] F1_P3 = -8'sd55;
    localparam logic signed [7:0] F1_P4 = -8'sd60;

    // one queue entry: a data byte with its line context, a history clear, or both
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] shift;
        logic [3:0] pred;
        logic       loop_point;
        logic       last_sample;
        logic       clr;
        logic       has_data;
    } entry_t;

    typedef struct packed {
        logic [3:0] pos;
        logic       ended;
    } front_status_t;

    function automatic logic signed [7:0] coef_new(input logic [3:0] p);
        logic signed [7:0] c;
        case (p)
            4'd1:    c = F0_P1;
            4'd2:    c = F0_P2;
            4'd3:    c = F0_P3;
            4'd4:    c = F0_P4;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [7:0] coef_old(input logic [3:0] p);
        logic signed [7:0] c;
        case (p)
            4'd2:    c = F1_P2;
            4'd3:    c = F1_P3;
            4'd4:    c = F1_P4;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

/* sv/vag_front.sv */
module vag_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output vag_pkg::entry_t       q_entry,
    output vag_pkg::front_status_t status
);
    import vag_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic [3:0] shift_reg, shift_next;
    logic [3:0] pred_reg, pred_next;
    logic [7:0] flags_reg, flags_next;
    logic [1:0] lcnt_reg, lcnt_next;
    logic       ended_reg, ended_next;
    logic       accept;
    logic       is_data;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_data  = !ended_reg && (pos_reg >= POS_FIRST);
    assign q_push   = accept && (is_data || last_byte);

    always_comb
    begin
        q_entry.data_byte   = data_byte;
        q_entry.shift       = shift_reg;
        q_entry.pred        = pred_reg;
        q_entry.loop_point  = (pos_reg == POS_FIRST) && flags_reg[FLAG_LOOP]
                              && (lcnt_reg >= LCNT_LOOP);
        q_entry.last_sample = last_byte || ((pos_reg == POS_LAST) && flags_reg[FLAG_END]);
        q_entry.clr         = last_byte;
        q_entry.has_data    = is_data;
    end

    assign status.pos   = pos_reg;
    assign status.ended = ended_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        shift_next = shift_reg;
        pred_next  = pred_reg;
        flags_next = flags_reg;
        lcnt_next  = lcnt_reg;
        ended_next = ended_reg;
        if (accept)
        begin
            if (!ended_reg)
            begin
                if (pos_reg == POS_SHIFT)
                begin
                    shift_next = data_byte[3:0];
                    pred_next  = data_byte[7:4];
                end
                else if (pos_reg == POS_FLAGS)
                begin
                    flags_next = data_byte;
                end
                if (pos_reg == POS_LAST)
                begin
                    if (lcnt_reg != LCNT_MAX)
                        lcnt_next = lcnt_reg + 2'd1;
                    if (flags_reg[FLAG_END])
                        ended_next = 1'b1;
                end
                pos_next = pos_reg + 4'd1;
            end
            if (last_byte)
            begin
                pos_next   = '0;
                shift_next = '0;
                pred_next  = '0;
                flags_next = '0;
                lcnt_next  = '0;
                ended_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            shift_reg <= '0;
            pred_reg  <= '0;
            flags_reg <= '0;
            lcnt_reg  <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            pred_reg  <= pred_next;
            flags_reg <= flags_next;
            lcnt_reg  <= lcnt_next;
            ended_reg <= ended_next;
        end
    end

endmodule

/* sv/vag_fifo.sv */
module vag_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  vag_pkg::entry_t              push_entry,
    output logic                         full,
    input  logic                         pop,
    output logic                         head_valid,
    output vag_pkg::entry_t              head_entry,
    output logic [vag_pkg::QCNT_W-1:0]   count
);
    import vag_pkg::*;

    entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign count      = cnt_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/vag_back.sv */
module vag_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  vag_pkg::entry_t       head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    sample,
    output logic                  loop_point,
    output logic                  last_sample
);
    import vag_pkg::*;

    logic                phase_reg, phase_next;
    logic signed [15:0]  hnew_reg, hnew_next;
    logic signed [15:0]  hold_reg, hold_next;
    logic signed [15:0]  sample_reg;
    logic                lp_reg, ls_reg;
    logic                valid_reg, valid_next;

    logic                adv;
    logic                fire;
    logic                clr_only;
    logic [3:0]          nib;
    logic signed [15:0]  nib_v;
    logic signed [15:0]  raw;
    logic signed [24:0]  c0x, c1x, h0x, h1x, acc;
    logic signed [18:0]  pred;
    logic signed [19:0]  sum;
    logic signed [15:0]  sat;

    assign adv      = !valid_reg || !out_stall;
    assign fire     = head_valid && head_entry.has_data && adv;
    assign clr_only = head_valid && !head_entry.has_data;
    assign pop      = clr_only || (fire && phase_reg);

    // low nibble first
    assign nib   = phase_reg ? head_entry.data_byte[7:4] : head_entry.data_byte[3:0];
    assign nib_v = {nib, 12'b0};
    assign raw   = nib_v >>> head_entry.shift;

    always_comb
    begin
        c0x  = 25'(coef_new(head_entry.pred));
        c1x  = 25'(coef_old(head_entry.pred));
        h0x  = 25'(hnew_reg);
        h1x  = 25'(hold_reg);
        acc  = c0x * h0x + c1x * h1x;
        pred = acc[24:FILTER_SHIFT];
        sum  = 20'(raw) + 20'(pred);
        if (sum > 20'sd32767)
            sat = 16'sh7fff;
        else if (sum < -20'sd32768)
            sat = 16'sh8000;
        else
            sat = sum[15:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        hnew_next  = hnew_reg;
        hold_next  = hold_reg;
        valid_next = valid_reg && out_stall;
        if (fire)
        begin
            valid_next = 1'b1;
            phase_next = !phase_reg;
            if (phase_reg && head_entry.clr)
            begin
                hnew_next = '0;
                hold_next = '0;
            end
            else
            begin
                hold_next = hnew_reg;
                hnew_next = sat;
            end
        end
        else if (clr_only)
        begin
            hnew_next = '0;
            hold_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sample_reg <= sat;
            lp_reg     <= head_entry.loop_point && !phase_reg;
            ls_reg     <= head_entry.last_sample && phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            hnew_reg  <= '0;
            hold_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hnew_reg  <= hnew_next;
            hold_reg  <= hold_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign sample      = sample_reg;
    assign loop_point  = lp_reg;
    assign last_sample = ls_reg;

endmodule

/* sv/vag_adpcm_decoder.sv */
// Path: an accepted data byte is written into the queue; the back end then decodes it,
// low nibble first, into the registered outputs (sample, out_valid), two samples per byte.
// Throughput: the predictor/history loop in the back end makes one sample per cycle
// while the output does not stall and the queue holds a data byte. Header bytes give no sample.
// Reset (rst_n low, async) clears line position, flags, history, queue and output valid.
module vag_adpcm_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    output logic               loop_point,
    output logic               last_sample
);
    import vag_pkg::*;

    entry_t              push_entry;
    entry_t              head_entry;
    front_status_t       fstat;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                head_valid;
    logic [QCNT_W-1:0]   q_count;

    vag_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .status    (fstat)
    );

    vag_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .count      (q_count)
    );

    vag_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .loop_point  (loop_point),
        .last_sample (last_sample)
    );

`ifndef ASSERT_OFF
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(loop_point && last_sample))
        else $error("loop_point and last_sample on one sample");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) |=> (fstat.pos == POS_SHIFT && !fstat.ended))
        else $error("front not back at line start after last item");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");
`endif

endmodule
